### sv/abf_pkg.sv
// Shared types, constants and arithmetic helpers for the alpha-beta track filter.
package abf_pkg;

  localparam int WIN_DEPTH  = 16;
  localparam int WIN_AW     = 4;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DVD_W      = 68;
  localparam int DVS_W      = 48;
  localparam int DIV_CNT_W  = 7;

  localparam logic [15:0] DT_CAP          = 16'hFFFF;
  localparam logic [15:0] MAX_STEPS_RST   = 16'd10;
  localparam logic [4:0]  WINDOW_SIZE_RST = 5'd8;
  localparam logic [16:0] GAIN_ONE        = 17'h10000;
  localparam logic [16:0] GAIN_MAX        = 17'h1FFFF;
  localparam logic [67:0] BETA_NUM        = 68'd393216;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_MEASURE = 2'd1,
    OP_COAST   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_MAX_STEPS   = 1'b0,
    CFG_WINDOW_SIZE = 1'b1
  } cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_LOAD, ST_LD_VX, ST_LD_VXW, ST_LD_VY, ST_LD_VYW,
    ST_GAIN_MUL, ST_GAIN_A, ST_GAIN_AW, ST_GAIN_B, ST_GAIN_BW,
    ST_RDH, ST_BASE, ST_ACC0, ST_ACC1, ST_ACC2, ST_ACC3, ST_ACC4,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
    ST_AX_SLOPE, ST_AX_SLOPE_W, ST_AX_C0M, ST_AX_C0D, ST_AX_C0W, ST_AX_PRED,
    ST_GCHK, ST_RES, ST_EXM, ST_EXA, ST_EYA, ST_VX, ST_VXW, ST_VYM, ST_VY,
    ST_VYW, ST_PUSH
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -72'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // saturate a sign/magnitude quotient
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [67:0] m);
    if (!neg) return (m > 68'd2147483647) ? 32'sh7FFFFFFF : $signed(m[31:0]);
    else return (m > 68'd2147483648) ? 32'sh80000000 : $signed(~m[31:0] + 32'd1);
  endfunction

  // signed shift that truncates toward zero
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (v + bias) >>> sh;
  endfunction

  // wrapped time difference, capped
  function automatic logic [15:0] tdiff(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d > 32'(DT_CAP)) ? DT_CAP : d[15:0];
  endfunction

endpackage

### sv/abf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module abf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [abf_pkg::DVD_W-1:0]  dividend,
  input  logic [abf_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [abf_pkg::DVD_W-1:0]  quotient
);
  import abf_pkg::*;

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0]     rem_r, dvs_r;
  logic [DVD_W-1:0]     quo_r;
  logic [DVS_W:0]       trial;
  logic                 take;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/alpha_beta_ls_track_filter.sv
// Two-axis alpha-beta tracker with least-squares window prediction.
// One item at a time; in_ready is high only while idle. Divisions run on a shared
// 68-step divider, products use one shared multiplier. Load adds two divisions when
// velocity is recomputed. Measure/coast walk every window entry and use up to eight
// divisions, and can stall on the result. Op 3 is accepted and gives no result.
// Synchronous active-low reset clears control and track state; window not cleared.
module alpha_beta_ls_track_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [abf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [abf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic signed [31:0]              in_pos_x,
  input  logic signed [31:0]              in_pos_y,
  input  logic [31:0]                     in_sample_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              out_est_x,
  output logic signed [31:0]              out_est_y,
  output logic [31:0]                     out_est_time,
  output logic signed [31:0]              out_vel_x,
  output logic signed [31:0]              out_vel_y
);
  import abf_pkg::*;

  state_t state_r, state_nxt;

  logic [15:0] max_steps_r;
  logic [4:0]  window_size_r;
  logic [4:0]  lim;

  op_t                op_r;
  logic signed [31:0] in_x_r, in_y_r;
  logic [31:0]        in_t_r;

  logic [CNT_W-1:0]   win_count_r;
  logic [WIN_AW-1:0]  win_head_r;
  logic signed [31:0] filt_x_r, filt_y_r, vel_x_r, vel_y_r, first_x_r, first_y_r;
  logic [31:0]        filt_time_r, first_time_r;
  logic [15:0]        step_r, gn_r;
  logic [16:0]        alpha_r, beta_r;

  logic signed [31:0] base_x_r, base_y_r;
  logic [31:0]        base_t_r;
  logic [CNT_W-1:0]   idx_r;
  logic [15:0]        dt_r, dtq_r;
  logic signed [32:0] dx_r, dy_r;
  logic [19:0]        st_r;
  logic [35:0]        st2_r;
  logic signed [36:0] sx_r, sy_r;
  logic signed [53:0] sxt_r, syt_r;
  logic signed [41:0] den_r;
  logic signed [59:0] numx_r, numy_r;
  logic               axis_r, neg_r;
  logic signed [31:0] slope_r, px_r, py_r, ex_r, ey_r;
  logic signed [53:0] c0_r;
  logic signed [32:0] rx_x_r, rx_y_r, dtf_r, dld_r;
  logic [31:0]        d_r;
  logic signed [63:0] prod_r;

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_vx_r, out_vy_r;
  logic [31:0]        out_t_r;

  // window memory: {time, y, x}
  logic [95:0]        win_mem [WIN_DEPTH];
  logic [95:0]        rd_data_r;
  logic [WIN_AW-1:0]  rd_addr;
  logic               mem_we;
  logic [WIN_AW-1:0]  mem_waddr;
  logic [95:0]        mem_wdata;

  logic signed [55:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [76:0] mul_p;
  logic               mul_en;

  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_dvd, div_q;
  logic [DVS_W-1:0]   div_dvs;

  logic signed [31:0] rd_x, rd_y;
  logic [31:0]        rd_t;
  logic [15:0]        dt_w;
  logic signed [32:0] dx_w, dy_w;
  logic               accept, out_free;
  logic signed [36:0] sx_ax;
  logic signed [59:0] num_ax;
  logic [59:0]        num_mag;
  logic signed [31:0] vel_ax, base_ax;
  logic signed [53:0] numer_w;
  logic [53:0]        numer_mag;
  logic signed [63:0] p16_w;
  logic signed [31:0] pred_w;
  logic signed [63:0] prod_mag_s;
  logic [32:0]        dtf_mag, dld_mag, ldx_mag, ldy_mag;
  logic signed [32:0] ldx_w, ldy_w;
  logic [31:0]        ft_eff;
  logic signed [71:0] q_signed;
  logic               full;
  logic [CNT_W-1:0]   c1, c2;
  logic [WIN_AW-1:0]  h1;
  logic [15:0]        step_inc;
  logic [16:0]        two_n_m1;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign lim = (window_size_r < 5'd2) ? 5'd2 :
               (window_size_r > 5'(WIN_DEPTH)) ? 5'(WIN_DEPTH) : window_size_r;

  assign rd_x = $signed(rd_data_r[31:0]);
  assign rd_y = $signed(rd_data_r[63:32]);
  assign rd_t = rd_data_r[95:64];
  assign dt_w = tdiff(rd_t, base_t_r);
  assign dx_w = 33'(rd_x) - 33'(base_x_r);
  assign dy_w = 33'(rd_y) - 33'(base_y_r);

  assign rd_addr = win_head_r +
                   ((state_r == ST_ACC4) ? WIN_AW'(idx_r + 5'd1) : idx_r[WIN_AW-1:0]);

  assign sx_ax   = axis_r ? sy_r : sx_r;
  assign num_ax  = axis_r ? numy_r : numx_r;
  assign num_mag = num_ax[59] ? 60'(-num_ax) : 60'(num_ax);
  assign vel_ax  = axis_r ? vel_y_r : vel_x_r;
  assign base_ax = axis_r ? base_y_r : base_x_r;
  assign numer_w   = (54'(sx_ax) <<< 8) - $signed(prod_r[53:0]);
  assign numer_mag = numer_w[53] ? 54'(-numer_w) : 54'(numer_w);
  assign p16_w  = 64'(c0_r) + prod_r;
  assign pred_w = sat32(72'(base_ax) + 72'(trunc_shr(p16_w, 8)));

  assign prod_mag_s = prod_r[63] ? -prod_r : prod_r;
  assign dtf_mag    = dtf_r[32] ? 33'(-dtf_r) : 33'(dtf_r);
  assign dld_mag    = dld_r[32] ? 33'(-dld_r) : 33'(dld_r);
  assign ldx_w      = 33'(in_x_r) - 33'(first_x_r);
  assign ldy_w      = 33'(in_y_r) - 33'(first_y_r);
  assign ldx_mag    = ldx_w[32] ? 33'(-ldx_w) : 33'(ldx_w);
  assign ldy_mag    = ldy_w[32] ? 33'(-ldy_w) : 33'(ldy_w);
  assign ft_eff     = (win_count_r == '0) ? in_t_r : first_time_r;
  assign q_signed   = neg_r ? -$signed({4'b0, div_q}) : $signed({4'b0, div_q});

  assign full = win_count_r[CNT_W-1];
  assign c1   = full ? win_count_r - 5'd1 : win_count_r;
  assign h1   = full ? win_head_r + 4'd1 : win_head_r;
  assign c2   = c1 + 5'd1;

  assign step_inc = (step_r != 16'hFFFF) ? step_r + 16'd1 : step_r;
  assign two_n_m1 = {gn_r, 1'b0} - 17'd1;

  assign mul_p = mul_a * mul_b;

  abf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    mem_we    = 1'b0;
    mem_waddr = h1 + c1[WIN_AW-1:0];
    mem_wdata = {in_t_r, ey_r, ex_r};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_op))
            OP_LOAD:              state_nxt = ST_LOAD;
            OP_MEASURE, OP_COAST: state_nxt = (win_count_r == '0) ? ST_GCHK : ST_RDH;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (win_count_r < lim) begin
          mem_we    = 1'b1;
          mem_waddr = win_head_r + win_count_r[WIN_AW-1:0];
        end
        mem_wdata = {in_t_r, in_y_r, in_x_r};
        state_nxt = (in_t_r != ft_eff) ? ST_LD_VX : ST_GAIN_MUL;
      end
      ST_LD_VX: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({ldx_mag, 8'd0});
        div_dvs   = DVS_W'(dld_mag);
        state_nxt = ST_LD_VXW;
      end
      ST_LD_VXW: if (div_done) state_nxt = ST_LD_VY;
      ST_LD_VY: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({ldy_mag, 8'd0});
        div_dvs   = DVS_W'(dld_mag);
        state_nxt = ST_LD_VYW;
      end
      ST_LD_VYW: if (div_done) state_nxt = ST_GAIN_MUL;
      ST_GAIN_MUL: begin
        mul_en    = 1'b1;
        mul_a     = 56'($signed({2'b0, gn_r} + 18'd1));
        mul_b     = 21'($signed({1'b0, gn_r}));
        state_nxt = ST_GAIN_A;
      end
      ST_GAIN_A: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({two_n_m1, 17'd0}) + DVD_W'(prod_r[31:1]);
        div_dvs   = DVS_W'(prod_r[31:0]);
        state_nxt = ST_GAIN_AW;
      end
      ST_GAIN_AW: if (div_done) state_nxt = ST_GAIN_B;
      ST_GAIN_B: begin
        div_start = 1'b1;
        div_dvd   = BETA_NUM + DVD_W'(d_r[31:1]);
        div_dvs   = DVS_W'(d_r);
        state_nxt = ST_GAIN_BW;
      end
      ST_GAIN_BW: if (div_done) state_nxt = (op_r == OP_LOAD) ? ST_IDLE : ST_RES;
      ST_RDH:  state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_ACC0;
      ST_ACC0: state_nxt = ST_ACC1;
      ST_ACC1: begin
        mul_en    = 1'b1;
        mul_a     = 56'($signed({1'b0, dt_r}));
        mul_b     = 21'($signed({1'b0, dt_r}));
        state_nxt = ST_ACC2;
      end
      ST_ACC2: begin
        mul_en    = 1'b1;
        mul_a     = 56'(dx_r);
        mul_b     = 21'($signed({1'b0, dt_r}));
        state_nxt = ST_ACC3;
      end
      ST_ACC3: begin
        mul_en    = 1'b1;
        mul_a     = 56'(dy_r);
        mul_b     = 21'($signed({1'b0, dt_r}));
        state_nxt = ST_ACC4;
      end
      ST_ACC4: state_nxt = (idx_r + 5'd1 == win_count_r) ? ST_P1 : ST_ACC0;
      ST_P1: begin
        mul_en    = 1'b1;
        mul_a     = 56'($signed({1'b0, st2_r}));
        mul_b     = 21'($signed({1'b0, win_count_r}));
        state_nxt = ST_P2;
      end
      ST_P2: begin
        mul_en    = 1'b1;
        mul_a     = 56'($signed({1'b0, st_r}));
        mul_b     = $signed({1'b0, st_r});
        state_nxt = ST_P3;
      end
      ST_P3: begin
        mul_en    = 1'b1;
        mul_a     = 56'(sxt_r);
        mul_b     = 21'($signed({1'b0, win_count_r}));
        state_nxt = ST_P4;
      end
      ST_P4: begin
        mul_en    = 1'b1;
        mul_a     = 56'(sx_r);
        mul_b     = $signed({1'b0, st_r});
        state_nxt = ST_P5;
      end
      ST_P5: begin
        mul_en    = 1'b1;
        mul_a     = 56'(syt_r);
        mul_b     = 21'($signed({1'b0, win_count_r}));
        state_nxt = ST_P6;
      end
      ST_P6: begin
        mul_en    = 1'b1;
        mul_a     = 56'(sy_r);
        mul_b     = $signed({1'b0, st_r});
        state_nxt = ST_P7;
      end
      ST_P7: state_nxt = ST_AX_SLOPE;
      ST_AX_SLOPE: begin
        if (den_r > 42'sd0) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'({num_mag, 8'd0});
          div_dvs   = DVS_W'(den_r[40:0]);
          state_nxt = ST_AX_SLOPE_W;
        end else begin
          state_nxt = ST_AX_C0M;
        end
      end
      ST_AX_SLOPE_W: if (div_done) state_nxt = ST_AX_C0M;
      ST_AX_C0M: begin
        mul_en    = 1'b1;
        mul_a     = 56'(slope_r);
        mul_b     = $signed({1'b0, st_r});
        state_nxt = ST_AX_C0D;
      end
      ST_AX_C0D: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(numer_mag);
        div_dvs   = DVS_W'(win_count_r);
        mul_en    = 1'b1;
        mul_a     = 56'(slope_r);
        mul_b     = 21'($signed({1'b0, dtq_r}));
        state_nxt = ST_AX_C0W;
      end
      ST_AX_C0W:  if (div_done) state_nxt = ST_AX_PRED;
      ST_AX_PRED: state_nxt = axis_r ? ST_GCHK : ST_AX_SLOPE;
      ST_GCHK: begin
        if (step_r < max_steps_r && step_r != 16'd0) state_nxt = ST_GAIN_MUL;
        else                                         state_nxt = ST_RES;
      end
      ST_RES: state_nxt = ST_EXM;
      ST_EXM: begin
        mul_en    = 1'b1;
        mul_a     = 56'(rx_x_r);
        mul_b     = 21'($signed({1'b0, alpha_r}));
        state_nxt = ST_EXA;
      end
      ST_EXA: begin
        mul_en    = 1'b1;
        mul_a     = 56'(rx_y_r);
        mul_b     = 21'($signed({1'b0, alpha_r}));
        state_nxt = ST_EYA;
      end
      ST_EYA: begin
        mul_en    = 1'b1;
        mul_a     = 56'(rx_x_r);
        mul_b     = 21'($signed({1'b0, beta_r}));
        state_nxt = ST_VX;
      end
      ST_VX: begin
        if (dtf_r != '0) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(prod_mag_s[51:0]);
          div_dvs   = DVS_W'({dtf_mag, 8'd0});
          state_nxt = ST_VXW;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_VXW: if (div_done) state_nxt = ST_VYM;
      ST_VYM: begin
        mul_en    = 1'b1;
        mul_a     = 56'(rx_y_r);
        mul_b     = 21'($signed({1'b0, beta_r}));
        state_nxt = ST_VY;
      end
      ST_VY: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod_mag_s[51:0]);
        div_dvs   = DVS_W'({dtf_mag, 8'd0});
        state_nxt = ST_VYW;
      end
      ST_VYW: if (div_done) state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          mem_we    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) win_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_p[63:0];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r   <= MAX_STEPS_RST;
      window_size_r <= WINDOW_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_STEPS:   max_steps_r   <= cfg_wdata;
        CFG_WINDOW_SIZE: window_size_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // track state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_count_r  <= '0;
      win_head_r   <= '0;
      filt_x_r     <= '0;
      filt_y_r     <= '0;
      filt_time_r  <= '0;
      vel_x_r      <= '0;
      vel_y_r      <= '0;
      step_r       <= '0;
      first_x_r    <= '0;
      first_y_r    <= '0;
      first_time_r <= '0;
      alpha_r      <= GAIN_ONE;
      beta_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == ST_PUSH && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                 out_valid_r <= 1'b0;

      case (state_r)
        ST_LOAD: begin
          if (win_count_r == '0) begin
            first_x_r    <= in_x_r;
            first_y_r    <= in_y_r;
            first_time_r <= in_t_r;
          end
          if (win_count_r < lim) win_count_r <= win_count_r + 5'd1;
          filt_x_r    <= in_x_r;
          filt_y_r    <= in_y_r;
          filt_time_r <= in_t_r;
          step_r      <= step_inc;
        end
        ST_LD_VXW:  if (div_done) vel_x_r <= sat_mag(neg_r, div_q);
        ST_LD_VYW:  if (div_done) vel_y_r <= sat_mag(neg_r, div_q);
        ST_GAIN_AW: if (div_done) alpha_r <= (div_q > DVD_W'(GAIN_MAX)) ? GAIN_MAX : div_q[16:0];
        ST_GAIN_BW: if (div_done) beta_r  <= (div_q > DVD_W'(GAIN_MAX)) ? GAIN_MAX : div_q[16:0];
        ST_GCHK:    if (step_r < max_steps_r) step_r <= step_r + 16'd1;
        ST_VXW:     if (div_done) vel_x_r <= sat32(72'(vel_x_r) + q_signed);
        ST_VYW:     if (div_done) vel_y_r <= sat32(72'(vel_y_r) + q_signed);
        ST_PUSH: begin
          if (out_free) begin
            filt_x_r    <= ex_r;
            filt_y_r    <= ey_r;
            filt_time_r <= in_t_r;
            if (c2 > lim) begin
              win_head_r  <= h1 + WIN_AW'(c2 - lim);
              win_count_r <= lim;
            end else begin
              win_head_r  <= h1;
              win_count_r <= c2;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_r   <= op_t'(in_op);
          in_x_r <= in_pos_x;
          in_y_r <= in_pos_y;
          in_t_r <= in_sample_time;
          idx_r  <= '0;
          axis_r <= 1'b0;
          px_r   <= filt_x_r;
          py_r   <= filt_y_r;
        end
      end
      ST_LOAD: begin
        gn_r  <= step_inc;
        dld_r <= $signed({1'b0, in_t_r}) - $signed({1'b0, ft_eff});
      end
      ST_LD_VX: neg_r <= ldx_w[32] ^ dld_r[32];
      ST_LD_VY: neg_r <= ldy_w[32] ^ dld_r[32];
      ST_GAIN_A: d_r <= prod_r[31:0];
      ST_RDH: begin
        st_r  <= '0;
        st2_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sxt_r <= '0;
        syt_r <= '0;
      end
      ST_BASE: begin
        base_x_r <= rd_x;
        base_y_r <= rd_y;
        base_t_r <= rd_t;
      end
      ST_ACC0: begin
        dt_r <= dt_w;
        dx_r <= dx_w;
        dy_r <= dy_w;
        st_r <= st_r + 20'(dt_w);
        sx_r <= sx_r + 37'(dx_w);
        sy_r <= sy_r + 37'(dy_w);
      end
      ST_ACC2: st2_r <= st2_r + prod_r[35:0];
      ST_ACC3: sxt_r <= sxt_r + $signed(prod_r[53:0]);
      ST_ACC4: begin
        syt_r <= syt_r + $signed(prod_r[53:0]);
        idx_r <= idx_r + 5'd1;
      end
      ST_P2: den_r  <= $signed(prod_r[41:0]);
      ST_P3: den_r  <= den_r - $signed(prod_r[41:0]);
      ST_P4: numx_r <= $signed(prod_r[59:0]);
      ST_P5: numx_r <= numx_r - $signed(prod_r[59:0]);
      ST_P6: numy_r <= $signed(prod_r[59:0]);
      ST_P7: begin
        numy_r <= numy_r - $signed(prod_r[59:0]);
        dtq_r  <= tdiff(in_t_r, base_t_r);
      end
      ST_AX_SLOPE: begin
        neg_r <= num_ax[59];
        if (!(den_r > 42'sd0)) slope_r <= vel_ax;
      end
      ST_AX_SLOPE_W: if (div_done) slope_r <= sat_mag(neg_r, div_q);
      ST_AX_C0D: neg_r <= numer_w[53];
      ST_AX_C0W: begin
        if (div_done) c0_r <= neg_r ? -$signed(div_q[53:0]) : $signed(div_q[53:0]);
      end
      ST_AX_PRED: begin
        if (axis_r) py_r <= pred_w;
        else        px_r <= pred_w;
        axis_r <= 1'b1;
      end
      ST_GCHK: gn_r <= step_r;
      ST_RES: begin
        rx_x_r <= (op_r == OP_COAST) ? 33'sd0 : 33'(in_x_r) - 33'(px_r);
        rx_y_r <= (op_r == OP_COAST) ? 33'sd0 : 33'(in_y_r) - 33'(py_r);
        dtf_r  <= $signed({1'b0, in_t_r}) - $signed({1'b0, filt_time_r});
      end
      ST_EXA: ex_r <= sat32(72'(px_r) + 72'(trunc_shr(prod_r, 16)));
      ST_EYA: ey_r <= sat32(72'(py_r) + 72'(trunc_shr(prod_r, 16)));
      ST_VX:  neg_r <= prod_r[63] ^ dtf_r[32];
      ST_VY:  neg_r <= prod_r[63] ^ dtf_r[32];
      ST_PUSH: begin
        if (out_free) begin
          out_x_r  <= ex_r;
          out_y_r  <= ey_r;
          out_t_r  <= in_t_r;
          out_vx_r <= vel_x_r;
          out_vy_r <= vel_y_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_est_x    = out_x_r;
  assign out_est_y    = out_y_r;
  assign out_est_time = out_t_r;
  assign out_vel_x    = out_vx_r;
  assign out_vel_y    = out_vy_r;

endmodule

### verif/tb.sv
// Self-checking bench for alpha_beta_ls_track_filter: random traffic against a track predictor.
module tb;
  import abf_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] t;
  } trk_in_t;

  typedef struct packed {
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] et;
    logic [31:0] vx;
    logic [31:0] vy;
  } trk_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic [31:0] in_sample_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_est_x, out_est_y, out_vel_x, out_vel_y;
  logic [31:0] out_est_time;

  alpha_beta_ls_track_filter u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  trk_in_t  pending_q[$];
  trk_out_t est_q[$];
  int errors = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;

  // predictor state
  longint wx[WIN_DEPTH], wy[WIN_DEPTH];
  logic [31:0] wt[WIN_DEPTH];
  int w_cnt, w_head;
  longint f_x, f_y, v_x, v_y, s_x, s_y;
  logic [31:0] f_t, s_t;
  int unsigned steps;
  longint g_a, g_b;
  int unsigned lim_steps, win_len;

  function automatic longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint tgap(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d > 32'd65535) ? 64'sd65535 : longint'(d);
  endfunction

  task automatic update_gains(int unsigned n);
    longint unsigned d;
    if (n == 0) return;
    d = longint'(n) * (longint'(n) + 1);
    g_a = (2 * (2 * longint'(n) - 1) * 65536 + d / 2) / d;
    g_b = (6 * 65536 + d / 2) / d;
    if (g_a > 'h1FFFF) g_a = 'h1FFFF;
    if (g_b > 'h1FFFF) g_b = 'h1FFFF;
  endtask

  function automatic longint slope_of(longint num, longint den, longint fb);
    longint unsigned m, q, r, v;
    bit neg;
    if (den <= 0) return fb;
    neg = num < 0;
    m = neg ? -num : num;
    q = m / den;
    r = m % den;
    v = (q >= 64'd4294967296) ? 64'd1 << 40 : q * 256 + (r * 256) / den;
    return clip(neg ? -longint'(v) : longint'(v));
  endfunction

  function automatic longint axis_est(longint base, longint sx, longint num, longint den,
                                     longint st, longint n, longint dq, longint vel);
    longint s, c0;
    s = slope_of(num, den, vel);
    c0 = (sx * 256 - s * st) / n;
    return clip(base + (c0 + s * dq) / 256);
  endfunction

  task automatic track_step(trk_in_t it);
    longint x, y, px, py, mx, my, rx, ry, ex, ey, dt, n, st, st2, sx, sy, sxt, syt;
    longint den, dq, ddt, dx, dy;
    int k, h;
    trk_out_t r;
    x = longint'($signed(it.px));
    y = longint'($signed(it.py));
    if (it.op == OP_NONE) return;
    if (it.op == OP_LOAD) begin
      if (w_cnt == 0) begin
        s_x = x; s_y = y; s_t = it.t;
      end
      if (w_cnt < win_len) begin
        k = (w_head + w_cnt) % WIN_DEPTH;
        wx[k] = x; wy[k] = y; wt[k] = it.t;
        w_cnt++;
      end
      dt = longint'(it.t) - longint'(s_t);
      if (dt != 0) begin
        v_x = clip(((x - s_x) * 256) / dt);
        v_y = clip(((y - s_y) * 256) / dt);
      end
      f_x = x; f_y = y; f_t = it.t;
      if (steps < 65535) steps++;
      update_gains(steps);
      return;
    end
    n = w_cnt;
    if (n == 0) begin
      px = f_x; py = f_y;
    end else begin
      h = w_head;
      st = 0; st2 = 0; sx = 0; sy = 0; sxt = 0; syt = 0;
      for (int i = 0; i < w_cnt; i++) begin
        k = (h + i) % WIN_DEPTH;
        ddt = tgap(wt[k], wt[h]);
        dx = wx[k] - wx[h];
        dy = wy[k] - wy[h];
        st += ddt; st2 += ddt * ddt; sx += dx; sy += dy;
        sxt += dx * ddt; syt += dy * ddt;
      end
      den = n * st2 - st * st;
      dq = tgap(it.t, wt[h]);
      px = axis_est(wx[h], sx, n * sxt - sx * st, den, st, n, dq, v_x);
      py = axis_est(wy[h], sy, n * syt - sy * st, den, st, n, dq, v_y);
    end
    if (it.op == OP_COAST) begin
      mx = px; my = py;
    end else begin
      mx = x; my = y;
    end
    if (steps < lim_steps) begin
      update_gains(steps);
      steps++;
    end
    rx = mx - px; ry = my - py;
    ex = clip(px + (g_a * rx) / 65536);
    ey = clip(py + (g_a * ry) / 65536);
    dt = longint'(it.t) - longint'(f_t);
    if (dt != 0) begin
      v_x = clip(v_x + (g_b * rx) / (256 * dt));
      v_y = clip(v_y + (g_b * ry) / (256 * dt));
    end
    f_x = ex; f_y = ey; f_t = it.t;
    if (w_cnt >= WIN_DEPTH) begin
      w_head = (w_head + 1) % WIN_DEPTH;
      w_cnt--;
    end
    k = (w_head + w_cnt) % WIN_DEPTH;
    wx[k] = ex; wy[k] = ey; wt[k] = it.t;
    w_cnt++;
    while (w_cnt > win_len) begin
      w_head = (w_head + 1) % WIN_DEPTH;
      w_cnt--;
    end
    r.ex = ex[31:0]; r.ey = ey[31:0]; r.et = it.t; r.vx = v_x[31:0]; r.vy = v_y[31:0];
    est_q.push_back(r);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 300);
  endfunction

  // driver
  always @(posedge clk) begin
    int g;
    if (in_valid && in_ready) begin
      track_step(pending_q.pop_front());
      g = pick_gap();
      if (g == 0 && pending_q.size() > 0) begin
        in_op <= pending_q[0].op;
        in_pos_x <= pending_q[0].px;
        in_pos_y <= pending_q[0].py;
        in_sample_time <= pending_q[0].t;
      end else begin
        in_valid <= 1'b0;
        in_gap <= g;
      end
    end else if (!in_valid && rst_n) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_q.size() > 0) begin
        in_valid <= 1'b1;
        in_op <= pending_q[0].op;
        in_pos_x <= pending_q[0].px;
        in_pos_y <= pending_q[0].py;
        in_sample_time <= pending_q[0].t;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    trk_out_t w;
    if (out_valid && out_ready) begin
      if (est_q.size() == 0) begin
        report("unexpected", out_est_time, '0);
      end else begin
        w = est_q.pop_front();
        if (out_est_x !== w.ex) report("est_x", out_est_x, w.ex);
        if (out_est_y !== w.ey) report("est_y", out_est_y, w.ey);
        if (out_est_time !== w.et) report("est_time", out_est_time, w.et);
        if (out_vel_x !== w.vx) report("vel_x", out_vel_x, w.vx);
        if (out_vel_y !== w.vy) report("vel_y", out_vel_y, w.vy);
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      out_gap <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 10000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic cfg_write(cfg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MAX_STEPS) lim_steps = v;
    else win_len = (v[4:0] < 2) ? 2 : (v[4:0] > WIN_DEPTH ? WIN_DEPTH : v[4:0]);
  endtask

  task automatic add(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] t);
    trk_in_t it;
    it.op = op; it.px = x; it.py = y; it.t = t;
    pending_q.push_back(it);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid && est_q.size() == 0);
    repeat (800) @(posedge clk);
  endtask

  // one track: loads then measure/coast with small random motion, plus occasional random ops
  task automatic random_track(int len);
    logic [31:0] t, x, y;
    int nl;
    t = $urandom;
    x = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000) - 100000;
    y = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000) - 100000;
    nl = $urandom_range(0, 5);
    for (int i = 0; i < len; i++) begin
      t = t + (($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 40));
      x = x + $urandom_range(0, 4000) - 2000;
      y = y + $urandom_range(0, 4000) - 2000;
      if ($urandom_range(0, 19) == 0)
        add($urandom_range(0, 3), $urandom, $urandom, t);
      else
        add(i < nl ? OP_LOAD : ($urandom_range(0, 3) == 0 ? OP_COAST : OP_MEASURE), x, y, t);
    end
  endtask

  initial begin
    w_cnt = 0; w_head = 0; f_x = 0; f_y = 0; v_x = 0; v_y = 0; s_x = 0; s_y = 0;
    f_t = 0; s_t = 0; steps = 0; g_a = 65536; g_b = 0;
    lim_steps = MAX_STEPS_RST; win_len = WINDOW_SIZE_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: measure on empty window, extremes, equal times, op 3, full window
    add(OP_MEASURE, 32'h7FFFFFFF, 32'h80000000, 32'd0);
    add(OP_COAST, 32'h0, 32'h0, 32'd5);
    add(OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add(OP_LOAD, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFF0);
    add(OP_LOAD, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFF0);
    add(OP_LOAD, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    add(OP_MEASURE, 32'h80000000, 32'h7FFFFFFF, 32'h00000010);
    add(OP_COAST, 32'h0, 32'h0, 32'h00000010);
    for (int i = 0; i < 10; i++) add(OP_LOAD, i * 300, -i * 200, 100 + i * 3);
    add(OP_MEASURE, 4000, -3000, 140);
    add(OP_COAST, 0, 0, 150);
    add(OP_MEASURE, 5000, -3500, 150);
    drain();

    cfg_write(CFG_MAX_STEPS, 16'd1);
    cfg_write(CFG_WINDOW_SIZE, 16'd2);
    random_track(60);
    drain();
    cfg_write(CFG_MAX_STEPS, 16'hFFFF);
    cfg_write(CFG_WINDOW_SIZE, 16'd16);
    random_track(120);
    drain();
    cfg_write(CFG_WINDOW_SIZE, 16'd31);
    random_track(100);
    drain();
    cfg_write(CFG_WINDOW_SIZE, 16'd0);
    cfg_write(CFG_MAX_STEPS, 16'd3);
    random_track(80);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_MAX_STEPS, $urandom_range(1, 40));
      cfg_write(CFG_WINDOW_SIZE, $urandom_range(2, 16));
      random_track(100);
      drain();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

### alpha_beta_ls_track_filter.f
sv/abf_pkg.sv
sv/abf_div.sv
sv/alpha_beta_ls_track_filter.sv
verif/tb.sv
